### sv/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg: shared types for the LRU page frame replacer
// Frame entry layout and per-cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

    localparam int PID_W  = 8;
    localparam int PAGE_W = 8;

    // One page frame: valid mark, owning process, page number.
    typedef struct packed {
        logic              valid;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
    } frame_t;

    // Control that the sequencer sends to every cell of the chain.
    typedef struct packed {
        logic cmp_en;     // latch match against the incoming request
        logic update;     // apply the list update this cycle
        logic evict_all;  // miss on a full list: whole chain shifts down
    } cell_ctrl_t;

endpackage : lpfr_pkg

`default_nettype wire

### sv/lru_page_frame_replacer_unit.sv
// ----------------------------------------------------------------------------
// lru_page_frame_replacer_unit: LRU page frame replacer, top level
// Chain of frame cells kept in least-recently-used-first order.
// ----------------------------------------------------------------------------
// Each request has a compare step and an update step: the accept edge latches
// a match flag in every cell (one compare per frame, in parallel), and the
// update edge shifts the chain and places the page. The result is then held
// in an output register while the next request is taken. The update of that
// next request waits as long as the previous result is still unaccepted. The
// update cycle's critical path is the first-match chain across the cells (an
// OR ripple of FRAMES stages).
// On a hit the matching frame drops out, frames above it close up and the
// page goes to the top of the occupied part; on a miss the page fills the
// first free frame, or, when all frames are used, frame 0 is evicted and the
// whole chain shifts down. frame_index reports the low 3 bits of the final
// position. No clearing pass: reset empties the chain at once.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_frame_replacer_unit
    import lpfr_pkg::*;
#(
    parameter int FRAMES = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    // request: [7:0] process_id, [15:8] page_number
    input  wire  [15:0] s_tdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // result: [0] hit, [3:1] frame_index, [4] evicted,
    //         [12:5] evicted_process_id, [20:13] evicted_page_number, [23:21] zero
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  wire         m_tready
);

    localparam int CNT_W = $clog2(FRAMES + 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    frame_t           req_reg;
    logic [23:0]      m_tdata_reg;
    logic             m_tvalid_reg;

    frame_t           new_frame;
    frame_t           frames  [FRAMES];
    frame_t           nbrs    [FRAMES];
    logic [FRAMES:0]  seen;
    logic [FRAMES-1:0] load_vec;
    logic [FRAMES-1:0] valid_vec;
    cell_ctrl_t       ctrl;
    logic             s_fire;
    logic             upd_go;
    logic             hit;
    logic             full;
    logic [CNT_W-1:0] ins_pos;
    logic [31:0]      pos_ext;
    frame_t           evict_frame;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign upd_go   = (state_reg == ST_UPDATE) && (!m_tvalid_reg || m_tready);
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // compare uses the incoming request, update uses the latched one
    always_comb begin
        new_frame.valid = 1'b1;
        if (s_fire) begin
            new_frame.pid  = s_tdata[7:0];
            new_frame.page = s_tdata[15:8];
        end else begin
            new_frame.pid  = req_reg.pid;
            new_frame.page = req_reg.page;
        end
    end

    assign hit  = seen[FRAMES];
    assign full = (count_reg == CNT_W'(FRAMES));

    always_comb begin
        if (hit) begin
            ins_pos = count_reg - CNT_W'(1);   // top of the occupied part
        end else if (full) begin
            ins_pos = CNT_W'(FRAMES - 1);
        end else begin
            ins_pos = count_reg;               // first free frame
        end
    end
    assign pos_ext = 32'(ins_pos);

    assign ctrl.cmp_en    = s_fire;
    assign ctrl.update    = upd_go;
    assign ctrl.evict_all = !hit && full;

    assign seen[0] = 1'b0;

    genvar j;
    generate
        for (j = 0; j < FRAMES; j++) begin : g_cell
            if (j == FRAMES - 1) begin : g_top
                assign nbrs[j] = '0;   // freed last slot reads empty
            end else begin : g_mid
                assign nbrs[j] = frames[j+1];
            end
            assign load_vec[j]  = (ins_pos == CNT_W'(j));
            assign valid_vec[j] = frames[j].valid;

            lpfr_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .load      (load_vec[j]),
                .new_frame (new_frame),
                .nbr_frame (nbrs[j]),
                .seen_in   (seen[j]),
                .seen_out  (seen[j+1]),
                .frame_q   (frames[j])
            );
        end
    endgenerate

    always_comb begin
        if (ctrl.evict_all) begin
            evict_frame = frames[0];
        end else begin
            evict_frame = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a new result replaces one leaving in the same cycle
            if (upd_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        req_reg.valid <= 1'b1;
                        req_reg.pid   <= s_tdata[7:0];
                        req_reg.page  <= s_tdata[15:8];
                        state_reg     <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (upd_go) begin
                        if (!hit && !full) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        m_tdata_reg  <= {3'b000, evict_frame.page, evict_frame.pid,
                                         ctrl.evict_all, pos_ext[2:0], hit};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- checks
    logic [FRAMES:0]   occ_onehot;
    logic [FRAMES:0]   occ_mask;
    assign occ_onehot = (FRAMES + 1)'(1) << count_reg;
    assign occ_mask   = occ_onehot - (FRAMES + 1)'(1);

    // valid frames always form a prefix whose length is the fill count
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_vec == occ_mask[FRAMES-1:0])
        else $error("valid frames do not match fill count");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(FRAMES))
        else $error("fill count above frame count");

    // an eviction only happens on a miss with all frames in use
    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_go && ctrl.evict_all |=> full && !m_tdata_reg[0])
        else $error("eviction without a full list");

    // a hit leaves the fill count unchanged
    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_go && hit |=> $stable(count_reg))
        else $error("fill count changed on hit");

endmodule : lru_page_frame_replacer_unit

`default_nettype wire

### sv/lpfr_cell.sv
// ----------------------------------------------------------------------------
// lpfr_cell: one page frame of the LRU chain
// Holds a frame, compares it to the request, and on update loads the new
// page, takes its upper neighbor's frame (close-up shift), or keeps its own.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_cell
    import lpfr_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  cell_ctrl_t       ctrl,
    input  wire              load,      // this cell is the insert position
    input  frame_t           new_frame, // request being placed
    input  frame_t           nbr_frame, // frame of the next higher cell
    input  wire              seen_in,   // a match exists below this cell
    output logic             seen_out,
    output frame_t           frame_q
);

    frame_t frame_reg;
    logic   match_reg;
    logic   shift;

    assign seen_out = seen_in | match_reg;
    assign shift    = seen_out | ctrl.evict_all;
    assign frame_q  = frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
            match_reg <= 1'b0;
        end else begin
            if (ctrl.cmp_en) begin
                match_reg <= frame_reg.valid && (frame_reg.pid == new_frame.pid)
                             && (frame_reg.page == new_frame.page);
            end
            if (ctrl.update) begin
                if (load) begin
                    frame_reg <= new_frame;
                end else if (shift) begin
                    frame_reg <= nbr_frame;
                end
            end
        end
    end

endmodule : lpfr_cell

`default_nettype wire

### tb/sv/lru_page_frame_replacer_unit_tb.sv
// ----------------------------------------------------------------------------
// lru_page_frame_replacer_unit_tb: self-checking bench for the LRU replacer
// Drives page references on the request stream and keeps its own copy of the
// LRU frame list. Every result on the output stream is compared, field by
// field, with the oldest predicted result. Both sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_frame_replacer_unit_tb;

    import lpfr_pkg::*;

    localparam int FRAMES    = 8;
    localparam int HALF_PER  = 6;
    localparam int RST_CYC   = 9;
    localparam int IDLE_PCT  = 30;
    localparam int RAND_REFS = 800;

    // request layout on s_tdata, highest field first
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [PID_W-1:0]  pid;
    } page_ref_t;

    // result layout on m_tdata, highest field first (hit in bit 0)
    typedef struct packed {
        logic [2:0]        pad;
        logic [PAGE_W-1:0] ev_page;
        logic [PID_W-1:0]  ev_pid;
        logic              evicted;
        logic [2:0]        frame_index;
        logic              hit;
    } lru_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    wire  [23:0] m_tdata;
    wire         m_tvalid;
    logic        m_tready = 1'b0;

    lru_page_frame_replacer_unit #(
        .FRAMES (FRAMES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #HALF_PER aclk = ~aclk;

    // Shadow LRU list, oldest first; valid frames form a prefix.
    logic              lru_valid [FRAMES];
    logic [PID_W-1:0]  lru_pid   [FRAMES];
    logic [PAGE_W-1:0] lru_page  [FRAMES];
    int                lru_used;

    lru_result_t pending_results[$];
    int          errors     = 0;
    int          refs_sent  = 0;
    int          hits_seen  = 0;
    int          evicts_seen = 0;
    int          results_checked = 0;
    bit          no_idle    = 1'b0;

    // Remove frame pos, close up the list and clear the freed top slot.
    function automatic void close_gap(int pos);
        for (int j = pos; j < FRAMES - 1; j++) begin
            lru_valid[j] = lru_valid[j+1];
            lru_pid[j]   = lru_pid[j+1];
            lru_page[j]  = lru_page[j+1];
        end
        lru_valid[FRAMES-1] = 1'b0;
        lru_pid[FRAMES-1]   = '0;
        lru_page[FRAMES-1]  = '0;
    endfunction

    // Apply one reference to the shadow list and return the expected result.
    function automatic lru_result_t predict_reference(logic [PID_W-1:0] pid,
                                                      logic [PAGE_W-1:0] page);
        lru_result_t r;
        int          pos;
        r   = '0;
        pos = -1;
        for (int j = 0; j < FRAMES; j++) begin
            if (pos < 0 && lru_valid[j] && lru_pid[j] == pid && lru_page[j] == page)
                pos = j;
        end
        if (pos >= 0) begin
            r.hit = 1'b1;
            close_gap(pos);
            lru_used--;
            pos = lru_used;
        end else if (lru_used < FRAMES) begin
            pos = lru_used;
        end else begin
            r.evicted = 1'b1;
            r.ev_pid  = lru_pid[0];
            r.ev_page = lru_page[0];
            close_gap(0);
            lru_used--;
            pos = FRAMES - 1;
        end
        lru_valid[pos] = 1'b1;
        lru_pid[pos]   = pid;
        lru_page[pos]  = page;
        lru_used++;
        r.frame_index = pos[2:0];
        return r;
    endfunction

    // Send one request; returns just after the edge that accepted it.
    task automatic send_reference(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page);
        page_ref_t   req;
        lru_result_t exp_r;
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge aclk);
        end
        req.pid  = pid;
        req.page = page;
        s_tdata  <= req;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        exp_r = predict_reference(pid, page);
        pending_results.push_back(exp_r);
        refs_sent++;
        hits_seen   += exp_r.hit;
        evicts_seen += exp_r.evicted;
    endtask

    // Mostly a small working set, so hits and evictions both happen often.
    task automatic send_random_reference(int pool_span);
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
        int                roll;
        int                idx;
        roll = $urandom_range(99);
        if (roll < 30 && lru_used > 0) begin
            idx  = $urandom_range(lru_used - 1);
            pid  = lru_pid[idx];
            page = lru_page[idx];
        end else if (roll < 80) begin
            pid  = PID_W'($urandom_range(pool_span)) ^ 8'hA0;
            page = PAGE_W'($urandom_range(pool_span)) ^ 8'h05;
        end else begin
            pid  = PID_W'($urandom_range(255));
            page = PAGE_W'($urandom_range(255));
        end
        send_reference(pid, page);
    endtask

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
        end
    endfunction

    // Output side: random backpressure plus result checking.
    always @(posedge aclk) begin
        lru_result_t act_r;
        lru_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            act_r = m_tdata;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_tdata);
            end else begin
                exp_r = pending_results.pop_front();
                results_checked++;
                check_field("hit", exp_r.hit, act_r.hit);
                check_field("frame_index", exp_r.frame_index, act_r.frame_index);
                check_field("evicted", exp_r.evicted, act_r.evicted);
                check_field("evicted_process_id", exp_r.ev_pid, act_r.ev_pid);
                check_field("evicted_page_number", exp_r.ev_page, act_r.ev_page);
                check_field("padding", exp_r.pad, act_r.pad);
            end
        end
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Fill, hits at the old end, the new end and the middle, hit on a full
    // list, evictions, and field extremes.
    task automatic test_directed_cases();
        send_reference(8'h00, 8'h00);
        send_reference(8'hFF, 8'hFF);
        send_reference(8'h00, 8'h00);   // hit on frame 0 of a partial list
        send_reference(8'h00, 8'hFF);   // same pid, other page
        send_reference(8'hFF, 8'h00);   // other pid, same page
        send_reference(8'hAA, 8'h55);
        send_reference(8'h55, 8'hAA);
        send_reference(8'h01, 8'h80);
        send_reference(8'h80, 8'h01);   // list now full
        send_reference(8'hFF, 8'hFF);   // hit on frame 0 of a full list
        send_reference(8'hFF, 8'hFF);   // hit on the last frame
        send_reference(8'hAA, 8'h55);   // hit in the middle
        send_reference(8'h12, 8'h34);   // miss on full list: eviction
        send_reference(8'h00, 8'h00);   // evicted page comes back in
        send_reference(8'h00, 8'hFF);   // miss again after eviction
        send_reference(8'h80, 8'h01);
        send_reference(8'h7F, 8'hFE);
        send_reference(8'hFE, 8'h7F);
    endtask

    task automatic test_random_traffic(int count);
        int span;
        span = 3;
        for (int i = 0; i < count; i++) begin
            if (i % 50 == 0)
                span = $urandom_range(1, 4);
            send_random_reference(span);
        end
    endtask

    // Back-to-back requests with no stalls on either side.
    task automatic test_streaming_no_idle(int count);
        no_idle = 1'b1;
        for (int i = 0; i < count; i++)
            send_random_reference(3);
        no_idle = 1'b0;
    endtask

    initial begin
        for (int j = 0; j < FRAMES; j++) begin
            lru_valid[j] = 1'b0;
            lru_pid[j]   = '0;
            lru_page[j]  = '0;
        end
        lru_used = 0;

        repeat (RST_CYC) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_random_traffic(RAND_REFS / 2);
        test_streaming_no_idle(RAND_REFS / 4);
        test_random_traffic(RAND_REFS / 4);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d page references (%0d hits, %0d evictions), %0d results checked.",
                 refs_sent, hits_seen, evicts_seen, results_checked);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3000000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule : lru_page_frame_replacer_unit_tb

`default_nettype wire

### filelist.f
sv/lpfr_pkg.sv
sv/lpfr_cell.sv
sv/lru_page_frame_replacer_unit.sv
tb/sv/lru_page_frame_replacer_unit_tb.sv
